/* src/btu_pkg.sv */
// Shared widths, register indexes and types for the beacon trilateration unit.
package btu_pkg;

   // Field and intermediate widths, fixed by the ranges of the fields.
   localparam int COORD_W  = 8;   // beacon coordinate, unsigned
   localparam int ASQ_W    = 16;  // coordinate squared, unsigned
   localparam int RANGE_W  = 9;   // measured range, unsigned
   localparam int SQ_W     = 18;  // range squared, unsigned
   localparam int DIFF_W   = 10;  // aa and bb terms, signed
   localparam int KC_W     = 18;  // constant part of cc, signed
   localparam int CC_W     = 20;  // cc terms, signed
   localparam int DET_W    = 21;  // determinant, signed
   localparam int DEN_W    = 20;  // determinant magnitude, unsigned
   localparam int PROD_W   = 30;  // cross products and numerators, signed
   localparam int MAG_W    = 29;  // numerator magnitude, unsigned
   localparam int POS_W    = 16;  // position result, signed

   localparam int POS_MAX     = 32767;
   localparam int POS_MIN_MAG = 32768;

   // Quotient bits resolved per divider stage.
   localparam int DIV_STEP_BITS = 4;

   // Configuration register map.
   localparam int CSR_IDX_W    = 3;
   localparam int ANCHOR_COUNT = 6;
   localparam logic [CSR_IDX_W-1:0] CSR_ANCHOR0_X = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ANCHOR0_Y = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ANCHOR1_X = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ANCHOR1_Y = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ANCHOR2_X = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_ANCHOR2_Y = 3'd5;

   // Per-item flags that ride along the divider.
   typedef struct packed {
      logic neg_x;
      logic neg_y;
      logic degenerate;
   } fix_side_type;

endpackage

/* src/btu_div_pipe.sv */
// Pipelined restoring divider: two unsigned numerators over one shared denominator.
module btu_div_pipe #(
   parameter int NUM_W     = btu_pkg::MAG_W,
   parameter int DEN_W     = btu_pkg::DEN_W,
   parameter int STEP_BITS = btu_pkg::DIV_STEP_BITS,
   localparam int STAGES   = (NUM_W + STEP_BITS - 1) / STEP_BITS,
   localparam int QUO_W    = STAGES * STEP_BITS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  logic                 in_valid,
   input  btu_pkg::fix_side_type in_side,
   input  logic [DEN_W-1:0]     in_den,
   input  logic [NUM_W-1:0]     in_num_x,
   input  logic [NUM_W-1:0]     in_num_y,
   output logic                 out_valid,
   output btu_pkg::fix_side_type out_side,
   output logic [QUO_W-1:0]     out_quo_x,
   output logic [QUO_W-1:0]     out_quo_y
);

   // The remainder field needs one bit above the denominator for the shifted value.
   localparam int REM_W  = DEN_W + 1;
   localparam int WORK_W = REM_W + QUO_W;

   // Upper field is the partial remainder; lower field holds the numerator bits
   // still to be consumed, with quotient bits shifting in from the bottom.
   function automatic logic [WORK_W-1:0] div_steps(input logic [WORK_W-1:0] work,
                                                   input logic [DEN_W-1:0]  den);
      logic [WORK_W-1:0] w;
      w = work;
      for (int k = 0; k < STEP_BITS; k++) begin
         w = w << 1;
         if (w[WORK_W-1 -: REM_W] >= {1'b0, den}) begin
            w[WORK_W-1 -: REM_W] = w[WORK_W-1 -: REM_W] - {1'b0, den};
            w[0] = 1'b1;
         end
      end
      return w;
   endfunction

   logic [WORK_W-1:0]     work_x_ff [STAGES];
   logic [WORK_W-1:0]     work_y_ff [STAGES];
   logic [DEN_W-1:0]      den_ff    [STAGES];
   btu_pkg::fix_side_type side_ff   [STAGES];
   logic                  valid_ff  [STAGES];

   for (genvar s = 0; s < STAGES; s++) begin : g_stage
      logic [WORK_W-1:0]     work_x_in;
      logic [WORK_W-1:0]     work_y_in;
      logic [DEN_W-1:0]      den_in;
      btu_pkg::fix_side_type side_in;
      logic                  valid_in;

      if (s == 0) begin : g_first
         always_comb begin
            work_x_in = div_steps({{REM_W{1'b0}}, QUO_W'(in_num_x)}, in_den);
            work_y_in = div_steps({{REM_W{1'b0}}, QUO_W'(in_num_y)}, in_den);
            den_in    = in_den;
            side_in   = in_side;
            valid_in  = in_valid;
         end
      end else begin : g_next
         always_comb begin
            work_x_in = div_steps(work_x_ff[s-1], den_ff[s-1]);
            work_y_in = div_steps(work_y_ff[s-1], den_ff[s-1]);
            den_in    = den_ff[s-1];
            side_in   = side_ff[s-1];
            valid_in  = valid_ff[s-1];
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            work_x_ff[s] <= work_x_in;
            work_y_ff[s] <= work_y_in;
            den_ff[s]    <= den_in;
            side_ff[s]   <= side_in;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else if (advance) begin
            valid_ff[s] <= valid_in;
         end
      end
   end

   assign out_valid = valid_ff[STAGES-1];
   assign out_side  = side_ff[STAGES-1];
   assign out_quo_x = work_x_ff[STAGES-1][QUO_W-1:0];
   assign out_quo_y = work_y_ff[STAGES-1][QUO_W-1:0];

endmodule

/* src/beacon_trilateration_unit.sv */
// Top level of the beacon trilateration unit: 2-D position from three beacon ranges.
//
//   Channel   Direction  Handshake             Payload
//   req_      in         req_valid/req_stall   req_range0, req_range1, req_range2
//   rsp_      out        rsp_valid/rsp_stall   rsp_pos_x, rsp_pos_y, rsp_degenerate
//   csr_      in         csr_wr_en             csr_index, csr_wdata (beacon coordinates)
//
// One item enters per cycle while req_stall is low; every item gives one result item.
// Items pass through the item stages, the divider stages and the output register.
// The whole pipeline advances together whenever the output register is empty or
// taken, so req_stall is high exactly while a result waits under rsp_stall.
// Reset clears the beacon coordinates to zero and empties the pipeline.
// After a write, derived values settle in order: pair terms, determinant, its sign.
//
// The linearized system is solved by Cramer's rule. The numerators and the
// determinant are split into magnitude and sign, the magnitudes are divided in a
// pipelined restoring divider, and the sign and 16-bit saturation are applied in
// the output stage. This gives the same truncation toward zero as signed C division.
// A zero determinant (collinear beacons) yields a zero position and the degenerate
// flag; the divider output is ignored for such an item.
module beacon_trilateration_unit #(
   parameter int DIV_STEP_BITS = btu_pkg::DIV_STEP_BITS
) (
   input  logic                           clock,
   input  logic                           reset,
   // Range item input.
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [btu_pkg::RANGE_W-1:0]    req_range0,
   input  logic [btu_pkg::RANGE_W-1:0]    req_range1,
   input  logic [btu_pkg::RANGE_W-1:0]    req_range2,
   // Position item output.
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic signed [btu_pkg::POS_W-1:0] rsp_pos_x,
   output logic signed [btu_pkg::POS_W-1:0] rsp_pos_y,
   output logic                           rsp_degenerate,
   // Configuration write port.
   input  logic                           csr_wr_en,
   input  logic [btu_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [btu_pkg::COORD_W-1:0]    csr_wdata
);

   localparam int COORD_W  = btu_pkg::COORD_W;
   localparam int ASQ_W    = btu_pkg::ASQ_W;
   localparam int RANGE_W  = btu_pkg::RANGE_W;
   localparam int SQ_W     = btu_pkg::SQ_W;
   localparam int DIFF_W   = btu_pkg::DIFF_W;
   localparam int KC_W     = btu_pkg::KC_W;
   localparam int CC_W     = btu_pkg::CC_W;
   localparam int DET_W    = btu_pkg::DET_W;
   localparam int DEN_W    = btu_pkg::DEN_W;
   localparam int PROD_W   = btu_pkg::PROD_W;
   localparam int MAG_W    = btu_pkg::MAG_W;
   localparam int POS_W    = btu_pkg::POS_W;
   localparam int IDX_W    = btu_pkg::CSR_IDX_W;
   localparam int DIV_STAGES = (MAG_W + DIV_STEP_BITS - 1) / DIV_STEP_BITS;
   localparam int QUO_W      = DIV_STAGES * DIV_STEP_BITS;

   // ---------------------------------------------------------------------------
   // Beacon coordinate registers.
   // ---------------------------------------------------------------------------
   logic [COORD_W-1:0] anchor_ff [btu_pkg::ANCHOR_COUNT];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < btu_pkg::ANCHOR_COUNT; k++) begin
            anchor_ff[k] <= '0;
         end
      end else if (csr_wr_en && (csr_index < IDX_W'(btu_pkg::ANCHOR_COUNT))) begin
         anchor_ff[csr_index] <= csr_wdata;
      end
   end

   logic [COORD_W-1:0] ax0, ay0, ax1, ay1, ax2, ay2;
   assign ax0 = anchor_ff[btu_pkg::CSR_ANCHOR0_X];
   assign ay0 = anchor_ff[btu_pkg::CSR_ANCHOR0_Y];
   assign ax1 = anchor_ff[btu_pkg::CSR_ANCHOR1_X];
   assign ay1 = anchor_ff[btu_pkg::CSR_ANCHOR1_Y];
   assign ax2 = anchor_ff[btu_pkg::CSR_ANCHOR2_X];
   assign ay2 = anchor_ff[btu_pkg::CSR_ANCHOR2_Y];

   // ---------------------------------------------------------------------------
   // Terms that depend on the beacons alone, registered in three steps.
   // Step one: aa, bb and the constant part of cc for both beacon pairs.
   // ---------------------------------------------------------------------------
   logic signed [DIFF_W-1:0] aa0_in, aa1_in, bb0_in, bb1_in;
   logic signed [DIFF_W-1:0] aa0_ff, aa1_ff, bb0_ff, bb1_ff;
   logic signed [KC_W-1:0]   kc0_in, kc1_in, kc0_ff, kc1_ff;
   logic [ASQ_W-1:0]         k0_sq, k1_sq, k2_sq;

   // Doubling a 9-bit signed difference keeps the exact value in ten bits.
   function automatic logic signed [DIFF_W-1:0] twice_diff(input logic [COORD_W-1:0] a,
                                                           input logic [COORD_W-1:0] b);
      logic [COORD_W:0] d;
      d = {1'b0, a} - {1'b0, b};
      return {d, 1'b0};
   endfunction

   always_comb begin
      aa0_in = twice_diff(ax0, ax1);
      aa1_in = twice_diff(ax1, ax2);
      bb0_in = twice_diff(ay0, ay1);
      bb1_in = twice_diff(ay1, ay2);
      k0_sq  = ASQ_W'(ax0 * ax0) + ASQ_W'(0);
      k1_sq  = ASQ_W'(ax1 * ax1);
      k2_sq  = ASQ_W'(ax2 * ax2);
      kc0_in = KC_W'(k0_sq) + KC_W'(ASQ_W'(ay0 * ay0))
             - KC_W'(k1_sq) - KC_W'(ASQ_W'(ay1 * ay1));
      kc1_in = KC_W'(k1_sq) + KC_W'(ASQ_W'(ay1 * ay1))
             - KC_W'(k2_sq) - KC_W'(ASQ_W'(ay2 * ay2));
   end

   // Step two: the determinant. Step three: its magnitude, sign and zero test.
   logic signed [DET_W-1:0] det_in, det_ff;
   logic [DET_W-1:0]        det_abs;
   logic [DEN_W-1:0]        det_mag_in, det_mag_ff;
   logic                    det_neg_ff, det_zero_ff;

   always_comb begin
      det_in     = DET_W'(aa0_ff) * DET_W'(bb1_ff) - DET_W'(aa1_ff) * DET_W'(bb0_ff);
      det_abs    = det_ff[DET_W-1] ? (-det_ff) : det_ff;
      det_mag_in = det_abs[DEN_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         aa0_ff      <= '0;
         aa1_ff      <= '0;
         bb0_ff      <= '0;
         bb1_ff      <= '0;
         kc0_ff      <= '0;
         kc1_ff      <= '0;
         det_ff      <= '0;
         det_mag_ff  <= '0;
         det_neg_ff  <= 1'b0;
         det_zero_ff <= 1'b1;
      end else begin
         aa0_ff      <= aa0_in;
         aa1_ff      <= aa1_in;
         bb0_ff      <= bb0_in;
         bb1_ff      <= bb1_in;
         kc0_ff      <= kc0_in;
         kc1_ff      <= kc1_in;
         det_ff      <= det_in;
         det_mag_ff  <= det_mag_in;
         det_neg_ff  <= det_ff[DET_W-1];
         det_zero_ff <= (det_ff == '0);
      end
   end

   // ---------------------------------------------------------------------------
   // Flow control: every stage moves together unless a result is held.
   // ---------------------------------------------------------------------------
   logic advance;
   logic rsp_valid_ff;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !advance;

   // ---------------------------------------------------------------------------
   // Item pipeline. Stage one captures the ranges.
   // ---------------------------------------------------------------------------
   logic [RANGE_W-1:0] r0_ff, r1_ff, r2_ff;
   logic               s1_valid_ff;

   // Stage two: squared ranges.
   logic [SQ_W-1:0] sq0_in, sq1_in, sq2_in, sq0_ff, sq1_ff, sq2_ff;
   logic            s2_valid_ff;

   // Stage three: cc for both beacon pairs.
   logic signed [CC_W-1:0] cc0_in, cc1_in, cc0_ff, cc1_ff;
   logic                   s3_valid_ff;

   // Stage four: the four cross products of Cramer's rule.
   logic signed [PROD_W-1:0] pbc_in, pbc_ff;   // bb0 * cc1
   logic signed [PROD_W-1:0] pcb_in, pcb_ff;   // bb1 * cc0
   logic signed [PROD_W-1:0] pac_in, pac_ff;   // aa0 * cc1
   logic signed [PROD_W-1:0] pca_in, pca_ff;   // aa1 * cc0
   logic                     s4_valid_ff;

   // Stage five: the signed numerators.
   logic signed [PROD_W-1:0] nx_in, ny_in, nx_ff, ny_ff;
   logic                     s5_valid_ff;

   // Stage six: magnitudes and result signs for the divider.
   logic [PROD_W-1:0]     nx_abs, ny_abs;
   logic [MAG_W-1:0]      mx_in, my_in, mx_ff, my_ff;
   logic [DEN_W-1:0]      den_ff;
   btu_pkg::fix_side_type side_in, side_ff;
   logic                  s6_valid_ff;

   always_comb begin
      sq0_in = SQ_W'(r0_ff * r0_ff);
      sq1_in = SQ_W'(r1_ff * r1_ff);
      sq2_in = SQ_W'(r2_ff * r2_ff);

      cc0_in = CC_W'(sq1_ff) - CC_W'(sq0_ff) + CC_W'(kc0_ff);
      cc1_in = CC_W'(sq2_ff) - CC_W'(sq1_ff) + CC_W'(kc1_ff);

      pbc_in = PROD_W'(bb0_ff) * PROD_W'(cc1_ff);
      pcb_in = PROD_W'(bb1_ff) * PROD_W'(cc0_ff);
      pac_in = PROD_W'(aa0_ff) * PROD_W'(cc1_ff);
      pca_in = PROD_W'(aa1_ff) * PROD_W'(cc0_ff);

      // The x numerator carries the leading minus sign of the solution.
      nx_in = pcb_ff - pbc_ff;
      ny_in = pac_ff - pca_ff;

      nx_abs = nx_ff[PROD_W-1] ? (-nx_ff) : nx_ff;
      ny_abs = ny_ff[PROD_W-1] ? (-ny_ff) : ny_ff;
      mx_in  = nx_abs[MAG_W-1:0];
      my_in  = ny_abs[MAG_W-1:0];
      side_in.neg_x      = nx_ff[PROD_W-1] ^ det_neg_ff;
      side_in.neg_y      = ny_ff[PROD_W-1] ^ det_neg_ff;
      side_in.degenerate = det_zero_ff;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         r0_ff   <= req_range0;
         r1_ff   <= req_range1;
         r2_ff   <= req_range2;
         sq0_ff  <= sq0_in;
         sq1_ff  <= sq1_in;
         sq2_ff  <= sq2_in;
         cc0_ff  <= cc0_in;
         cc1_ff  <= cc1_in;
         pbc_ff  <= pbc_in;
         pcb_ff  <= pcb_in;
         pac_ff  <= pac_in;
         pca_ff  <= pca_in;
         nx_ff   <= nx_in;
         ny_ff   <= ny_in;
         mx_ff   <= mx_in;
         my_ff   <= my_in;
         den_ff  <= det_mag_ff;
         side_ff <= side_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
         s6_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
         s5_valid_ff <= s4_valid_ff;
         s6_valid_ff <= s5_valid_ff;
      end
   end

   // ---------------------------------------------------------------------------
   // Magnitude divider.
   // ---------------------------------------------------------------------------
   logic                  div_valid;
   btu_pkg::fix_side_type div_side;
   logic [QUO_W-1:0]      div_quo_x, div_quo_y;

   btu_div_pipe #(
      .NUM_W     (MAG_W),
      .DEN_W     (DEN_W),
      .STEP_BITS (DIV_STEP_BITS)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (s6_valid_ff),
      .in_side   (side_ff),
      .in_den    (den_ff),
      .in_num_x  (mx_ff),
      .in_num_y  (my_ff),
      .out_valid (div_valid),
      .out_side  (div_side),
      .out_quo_x (div_quo_x),
      .out_quo_y (div_quo_y)
   );

   // ---------------------------------------------------------------------------
   // Output stage: sign, saturation and the collinear case.
   // ---------------------------------------------------------------------------
   function automatic logic [POS_W-1:0] apply_sign(input logic [QUO_W-1:0] mag,
                                                   input logic             neg);
      logic [POS_W-1:0] v;
      if (neg) begin
         if (mag > QUO_W'(btu_pkg::POS_MIN_MAG)) begin
            v = POS_W'(btu_pkg::POS_MIN_MAG);
         end else begin
            v = -mag[POS_W-1:0];
         end
      end else begin
         if (mag > QUO_W'(btu_pkg::POS_MAX)) begin
            v = POS_W'(btu_pkg::POS_MAX);
         end else begin
            v = mag[POS_W-1:0];
         end
      end
      return v;
   endfunction

   logic [POS_W-1:0] pos_x_in, pos_y_in, pos_x_ff, pos_y_ff;
   logic             degenerate_ff;

   always_comb begin
      if (div_side.degenerate) begin
         pos_x_in = '0;
         pos_y_in = '0;
      end else begin
         pos_x_in = apply_sign(div_quo_x, div_side.neg_x);
         pos_y_in = apply_sign(div_quo_y, div_side.neg_y);
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         pos_x_ff      <= pos_x_in;
         pos_y_ff      <= pos_y_in;
         degenerate_ff <= div_side.degenerate;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= div_valid;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_pos_x      = pos_x_ff;
   assign rsp_pos_y      = pos_y_ff;
   assign rsp_degenerate = degenerate_ff;

endmodule

/* bench/btu_checker.sv */
// Scoreboard for the beacon trilateration unit: predicts each position fix and compares.
`timescale 1ns / 100ps

module btu_checker
   import btu_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic                        req_stall,
   input  logic [RANGE_W-1:0]          req_range0,
   input  logic [RANGE_W-1:0]          req_range1,
   input  logic [RANGE_W-1:0]          req_range2,
   input  logic                        rsp_valid,
   input  logic                        rsp_stall,
   input  logic signed [POS_W-1:0]     rsp_pos_x,
   input  logic signed [POS_W-1:0]     rsp_pos_y,
   input  logic                        rsp_degenerate,
   input  logic                        csr_wr_en,
   input  logic [CSR_IDX_W-1:0]        csr_index,
   input  logic [COORD_W-1:0]          csr_wdata,
   output int                          fail_count,
   output int                          pending_count
);

   typedef struct packed {
      logic signed [POS_W-1:0] pos_x;
      logic signed [POS_W-1:0] pos_y;
      logic                    degenerate;
   } position_fix_type;

   logic [COORD_W-1:0] anchor_ff [ANCHOR_COUNT];
   position_fix_type   fix_queue [$];

   function automatic logic signed [POS_W-1:0] clamp_pos(input longint value);
      if (value > POS_MAX) return POS_W'(POS_MAX);
      if (value < -longint'(POS_MIN_MAG)) return POS_W'(POS_MIN_MAG);
      return value[POS_W-1:0];
   endfunction

   // Pairwise linearization of the three circles, then Cramer's rule.
   // SystemVerilog division of signed integers truncates toward zero.
   function automatic position_fix_type solve_fix(input logic [RANGE_W-1:0] r0,
                                                  input logic [RANGE_W-1:0] r1,
                                                  input logic [RANGE_W-1:0] r2);
      longint           rng [3];
      longint           bx [3];
      longint           by [3];
      longint           aa [2];
      longint           bb [2];
      longint           cc [2];
      longint           det;
      longint           num_x;
      longint           num_y;
      position_fix_type fix;
      rng[0] = r0;
      rng[1] = r1;
      rng[2] = r2;
      for (int k = 0; k < 3; k++) begin
         bx[k] = anchor_ff[2*k];
         by[k] = anchor_ff[2*k+1];
      end
      for (int k = 0; k < 2; k++) begin
         aa[k] = 2 * bx[k] - 2 * bx[k+1];
         bb[k] = 2 * by[k] - 2 * by[k+1];
         cc[k] = rng[k+1] * rng[k+1] - rng[k] * rng[k]
               + bx[k] * bx[k] + by[k] * by[k]
               - bx[k+1] * bx[k+1] - by[k+1] * by[k+1];
      end
      det = aa[0] * bb[1] - aa[1] * bb[0];
      if (det == 0) begin
         fix.pos_x      = '0;
         fix.pos_y      = '0;
         fix.degenerate = 1'b1;
      end else begin
         num_x          = -(bb[0] * cc[1] - bb[1] * cc[0]);
         num_y          = aa[0] * cc[1] - aa[1] * cc[0];
         fix.pos_x      = clamp_pos(num_x / det);
         fix.pos_y      = clamp_pos(num_y / det);
         fix.degenerate = 1'b0;
      end
      return fix;
   endfunction

   always @(posedge clock) begin
      position_fix_type got;
      position_fix_type want;
      int               faults;
      faults = 0;
      if (reset) begin
         for (int k = 0; k < ANCHOR_COUNT; k++) begin
            anchor_ff[k] <= '0;
         end
         fix_queue.delete();
      end else begin
         // Writes to indexes past the last beacon register are dropped.
         if (csr_wr_en && csr_index < ANCHOR_COUNT) begin
            anchor_ff[csr_index] <= csr_wdata;
         end
         if (req_valid && !req_stall) begin
            fix_queue.push_back(solve_fix(req_range0, req_range1, req_range2));
         end
         if (rsp_valid && !rsp_stall) begin
            got.pos_x      = rsp_pos_x;
            got.pos_y      = rsp_pos_y;
            got.degenerate = rsp_degenerate;
            if (fix_queue.size() == 0) begin
               $error("result item with none expected: pos_x %0d pos_y %0d degenerate %0b",
                      got.pos_x, got.pos_y, got.degenerate);
               faults++;
            end else begin
               want = fix_queue.pop_front();
               if (got.pos_x !== want.pos_x) begin
                  $error("pos_x: expected %0d, actual %0d", want.pos_x, got.pos_x);
                  faults++;
               end
               if (got.pos_y !== want.pos_y) begin
                  $error("pos_y: expected %0d, actual %0d", want.pos_y, got.pos_y);
                  faults++;
               end
               if (got.degenerate !== want.degenerate) begin
                  $error("degenerate: expected %0b, actual %0b",
                         want.degenerate, got.degenerate);
                  faults++;
               end
            end
         end
      end
      fail_count    <= reset ? 0 : fail_count + faults;
      pending_count <= fix_queue.size();
   end

endmodule

/* bench/tb_beacon_trilateration_unit.sv */
// Testbench top for the beacon trilateration unit: drives stimulus and gives the verdict.
`timescale 1ns / 100ps

module tb_beacon_trilateration_unit;
   import btu_pkg::*;

   localparam int HALF_PERIOD   = 4;
   localparam int RESET_CYCLES  = 12;
   // Allowance for the pipeline depth with the default divider.
   localparam int LATENCY       = 16;
   // Time for the derived beacon terms to settle after a register write.
   localparam int SETTLE_CYCLES = 4;
   localparam int RANDOM_PHASES = 10;
   localparam int PHASE_ITEMS   = 53;
   localparam int TIMEOUT_NS    = 4_000_000;

   // Indexes past the beacon registers; writes there must have no effect.
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HI = 3'd7;
   localparam logic [CSR_IDX_W-1:0] ANCHOR_REG [ANCHOR_COUNT] = '{
      CSR_ANCHOR0_X, CSR_ANCHOR0_Y, CSR_ANCHOR1_X,
      CSR_ANCHOR1_Y, CSR_ANCHOR2_X, CSR_ANCHOR2_Y
   };

   localparam logic [RANGE_W-1:0] RANGE_MAX = 9'h1FF;
   localparam logic [RANGE_W-1:0] RANGE_ODD = 9'h155;
   localparam logic [RANGE_W-1:0] RANGE_EVN = 9'h0AA;

   typedef enum int {
      LAYOUT_SCATTER,
      LAYOUT_CLUSTER,
      LAYOUT_CORNERS,
      LAYOUT_COLLINEAR
   } layout_kind_type;

   logic                     clock          = 1'b0;
   logic                     reset          = 1'b1;
   logic                     req_valid      = 1'b0;
   logic                     req_stall;
   logic [RANGE_W-1:0]       req_range0     = '0;
   logic [RANGE_W-1:0]       req_range1     = '0;
   logic [RANGE_W-1:0]       req_range2     = '0;
   logic                     rsp_valid;
   logic                     rsp_stall      = 1'b0;
   logic signed [POS_W-1:0]  rsp_pos_x;
   logic signed [POS_W-1:0]  rsp_pos_y;
   logic                     rsp_degenerate;
   logic                     csr_wr_en      = 1'b0;
   logic [CSR_IDX_W-1:0]     csr_index      = '0;
   logic [COORD_W-1:0]       csr_wdata      = '0;

   int                       fail_count;
   int                       pending_count;

   // When set, neither the sender nor the receiver inserts idle cycles.
   logic                     quiet_mode     = 1'b0;
   int                       stall_left_ff  = 0;

   // Stimulus-side copy of the beacon layout; written to the beacon registers and used to shape range items.
   logic [COORD_W-1:0]       anchor_now [ANCHOR_COUNT] = '{default: '0};

   always begin
      #HALF_PERIOD clock = 1'b1;
      #HALF_PERIOD clock = 1'b0;
   end

   beacon_trilateration_unit uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_range0     (req_range0),
      .req_range1     (req_range1),
      .req_range2     (req_range2),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_pos_x      (rsp_pos_x),
      .rsp_pos_y      (rsp_pos_y),
      .rsp_degenerate (rsp_degenerate),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   btu_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_range0     (req_range0),
      .req_range1     (req_range1),
      .req_range2     (req_range2),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_pos_x      (rsp_pos_x),
      .rsp_pos_y      (rsp_pos_y),
      .rsp_degenerate (rsp_degenerate),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .fail_count     (fail_count),
      .pending_count  (pending_count)
   );

   // Idle stretch lengths: mostly none, often a few cycles, now and then a long one.
   function automatic int idle_span();
      int pick;
      pick = $urandom_range(99);
      if (pick < 70) return 0;
      if (pick < 95) return $urandom_range(3, 1);
      return $urandom_range(40, 10);
   endfunction

   // The receiver stalls in bursts so that stalls land on every pipeline stage.
   always @(posedge clock) begin
      int hold;
      if (reset) begin
         rsp_stall     <= 1'b0;
         stall_left_ff <= 0;
      end else if (stall_left_ff > 0) begin
         stall_left_ff <= stall_left_ff - 1;
      end else if (quiet_mode) begin
         rsp_stall <= 1'b0;
      end else begin
         hold          = idle_span();
         rsp_stall     <= (hold != 0);
         stall_left_ff <= (hold > 0) ? hold - 1 : 0;
      end
   end

   // Presents one range item after an optional gap and returns at the edge that
   // accepts it. The valid stays high into the next item unless a gap follows.
   task automatic send_item(input logic [RANGE_W-1:0] r0,
                            input logic [RANGE_W-1:0] r1,
                            input logic [RANGE_W-1:0] r2);
      int gap;
      gap = quiet_mode ? 0 : idle_span();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_range0 <= r0;
      req_range1 <= r1;
      req_range2 <= r2;
      do @(posedge clock); while (req_stall);
   endtask

   // Stops sending and holds until every predicted position has come back.
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
   endtask

   // Loads anchor_now into the beacon registers while the pipeline is empty.
   // A junk write to a spare index goes first; it must leave the layout alone.
   task automatic program_anchors(input logic [CSR_IDX_W-1:0] spare);
      wait_drained();
      repeat (LATENCY) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= spare;
      csr_wdata <= COORD_W'($urandom_range(255));
      @(posedge clock);
      for (int k = 0; k < ANCHOR_COUNT; k++) begin
         csr_index <= ANCHOR_REG[k];
         csr_wdata <= anchor_now[k];
         @(posedge clock);
      end
      csr_wr_en <= 1'b0;
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      int                 tx;
      int                 ty;
      int                 dx;
      int                 dy;
      int                 pick;
      int                 rv;
      real                reach;
      layout_kind_type    kind;
      logic [RANGE_W-1:0] rng [3];

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // All beacons at the origin after reset, so every fix is degenerate.
      send_item('0, '0, '0);
      send_item(RANGE_MAX, RANGE_MAX, RANGE_MAX);
      send_item(RANGE_ODD, RANGE_EVN, RANGE_ODD);
      send_item(RANGE_EVN, RANGE_ODD, RANGE_EVN);

      // A unit triangle gives the smallest nonzero determinant, so large ranges
      // drive the quotient past the 16-bit limits in both directions.
      anchor_now = '{8'd0, 8'd0, 8'd1, 8'd0, 8'd0, 8'd1};
      program_anchors(CSR_SPARE_LO);
      send_item(RANGE_MAX, '0, '0);
      send_item('0, RANGE_MAX, '0);
      send_item('0, '0, RANGE_MAX);
      send_item(RANGE_MAX, RANGE_MAX, RANGE_MAX);
      send_item('0, '0, '0);
      send_item(RANGE_MAX, '0, RANGE_MAX);
      send_item(9'd3, 9'd4, 9'd5);
      send_item('0, RANGE_MAX, RANGE_MAX);

      // Beacons on the far corners of the coordinate space.
      anchor_now = '{8'd255, 8'd255, 8'd0, 8'd255, 8'd255, 8'd0};
      program_anchors(CSR_SPARE_HI);
      send_item('0, '0, '0);
      send_item(RANGE_MAX, RANGE_MAX, RANGE_MAX);
      send_item(RANGE_MAX, '0, '0);
      send_item('0, RANGE_MAX, '0);
      send_item('0, '0, RANGE_MAX);
      send_item(9'd360, 9'd255, 9'd255);
      send_item(9'd255, 9'd360, 9'd0);
      send_item(9'd100, 9'd200, 9'd300);

      // Random phases, each with its own beacon layout. Every third phase runs
      // with no idle cycles on either side.
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         kind = layout_kind_type'(p % 4);
         case (kind)
            LAYOUT_SCATTER: begin
               foreach (anchor_now[k]) anchor_now[k] = COORD_W'($urandom_range(255));
            end
            LAYOUT_CLUSTER: begin
               // Tight clusters give tiny determinants and saturated positions.
               tx = $urandom_range(247);
               ty = $urandom_range(247);
               for (int k = 0; k < 3; k++) begin
                  anchor_now[2*k]   = COORD_W'(tx + $urandom_range(8));
                  anchor_now[2*k+1] = COORD_W'(ty + $urandom_range(8));
               end
            end
            LAYOUT_CORNERS: begin
               foreach (anchor_now[k]) anchor_now[k] = $urandom_range(1) ? 8'd255 : 8'd0;
            end
            LAYOUT_COLLINEAR: begin
               tx = $urandom_range(85);
               ty = $urandom_range(85);
               dx = $urandom_range(85);
               dy = $urandom_range(85);
               for (int k = 0; k < 3; k++) begin
                  anchor_now[2*k]   = COORD_W'(tx + k * dx);
                  anchor_now[2*k+1] = COORD_W'(ty + k * dy);
               end
            end
            default: begin
               foreach (anchor_now[k]) anchor_now[k] = '0;
            end
         endcase
         quiet_mode <= (p % 3 == 2);
         program_anchors((p % 2 == 1) ? CSR_SPARE_HI : CSR_SPARE_LO);

         // Most items are ranges to a real point with a little noise; the rest
         // are uniform noise or pinned to the ends of the range field.
         repeat (PHASE_ITEMS) begin
            pick = $urandom_range(99);
            tx   = $urandom_range(255);
            ty   = $urandom_range(255);
            for (int k = 0; k < 3; k++) begin
               if (pick < 55) begin
                  dx    = tx - int'(anchor_now[2*k]);
                  dy    = ty - int'(anchor_now[2*k+1]);
                  reach = $sqrt(real'(dx * dx + dy * dy));
                  rv    = int'(reach) + int'($urandom_range(6)) - 3;
               end else if (pick < 85) begin
                  rv = $urandom_range(511);
               end else begin
                  case ($urandom_range(2))
                     0: rv = 0;
                     1: rv = 511;
                     default: rv = $urandom_range(511);
                  endcase
               end
               rng[k] = (rv < 0) ? '0 : (rv > 511) ? RANGE_MAX : rv[RANGE_W-1:0];
            end
            send_item(rng[0], rng[1], rng[2]);
         end
      end

      wait_drained();
      repeat (2 * LATENCY) @(posedge clock);
      if (fail_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   // Hard limit, far above the slowest legal run.
   initial begin
      #TIMEOUT_NS;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
